/* src/dcps_pkg.sv */
// Shared types, codes and defaults for the disk controller phase sequencer.
package dcps_pkg;

  localparam int WORDS_PER_SECTOR_DEF   = 128;
  localparam int SECTORS_PER_TRACK_DEF  = 24;
  localparam int HEADS_PER_CYLINDER_DEF = 2;
  localparam int UNITS_DEF              = 2;

  // item kinds on the input channel
  localparam logic [1:0] CMD_WRITE = 2'd0;
  localparam logic [1:0] CMD_READ  = 2'd1;
  localparam logic [1:0] CMD_TICK  = 2'd2;

  // function codes
  localparam logic [15:0] FN_SELECT  = 16'h0003;
  localparam logic [15:0] FN_CONTROL = 16'h0005;
  localparam logic [15:0] FN_START   = 16'h0015;
  localparam logic [15:0] CTL_RESET  = 16'h0080;

  localparam logic [15:0] ST_ERR_BITS = 16'h0048;

  // unit operations
  localparam logic [1:0] OP_READ    = 2'd0;
  localparam logic [1:0] OP_WRITE   = 2'd1;
  localparam logic [1:0] OP_COMPARE = 2'd2;

  localparam logic [1:0] XF_NONE   = 2'd0;
  localparam logic [1:0] XF_TO_MEM = 2'd1;
  localparam logic [1:0] XF_TO_DSK = 2'd2;

  localparam logic [3:0] WM_Q   = 4'b0001;
  localparam logic [3:0] WM_QCM = 4'b0011;
  localparam logic [3:0] WM_ADS = 4'b0100;
  localparam logic [3:0] WM_ADM = 4'b1000;

  localparam logic [3:0] IRQ_BASE = 4'd7;

  typedef enum logic [2:0] {
    K_NOP,
    K_SELECT,
    K_CONTROL,
    K_START,
    K_CMD_BAD,
    K_STATUS,
    K_STAT_BAD,
    K_TICK
  } kind_t;

  // classified word handed from front to back
  typedef struct packed {
    kind_t       kind;
    logic        unit;
    logic        sel_unit;
    logic [1:0]  sel_op;
    logic        ctl_hit;
    logic [15:0] a_value;
    logic        cm_zero;
    logic [15:0] q_value;
    logic [15:0] cm_value;
    logic [15:0] next_ads;
    logic [15:0] adm_value;
    logic [14:0] lsn;
  } job_t;

  typedef struct packed {
    logic [3:0]  reg_write_mask;
    logic [15:0] q_value;
    logic [15:0] cm_value;
    logic [15:0] ads_value;
    logic [15:0] adm_value;
    logic [15:0] status_out;
    logic [3:0]  interrupt_level;
    logic        suspend_request;
    logic        cmd_error;
    logic [1:0]  xfer_op;
    logic [14:0] xfer_sector;
  } result_t;

endpackage

/* src/dcps_if.sv */
// Channel interfaces: input words and result words.
interface dcps_in_if;
  logic        valid;
  logic        ready;
  logic [1:0]  cmd;
  logic        unit;
  logic [15:0] e_code;
  logic [15:0] a_value;
  logic [15:0] cm_in;
  logic [15:0] ads_in;
  logic [15:0] adm_in;
  modport source (output valid, cmd, unit, e_code, a_value, cm_in, ads_in, adm_in,
                  input ready);
  modport sink (input valid, cmd, unit, e_code, a_value, cm_in, ads_in, adm_in,
                output ready);
endinterface

interface dcps_out_if;
  logic        valid;
  logic        ready;
  logic [3:0]  reg_write_mask;
  logic [15:0] q_value;
  logic [15:0] cm_value;
  logic [15:0] ads_value;
  logic [15:0] adm_value;
  logic [15:0] status_out;
  logic [3:0]  interrupt_level;
  logic        suspend_request;
  logic        cmd_error;
  logic [1:0]  xfer_op;
  logic [14:0] xfer_sector;
  modport source (output valid, reg_write_mask, q_value, cm_value, ads_value, adm_value,
                  status_out, interrupt_level, suspend_request, cmd_error, xfer_op,
                  xfer_sector, input ready);
  modport sink (input valid, reg_write_mask, q_value, cm_value, ads_value, adm_value,
                status_out, interrupt_level, suspend_request, cmd_error, xfer_op,
                xfer_sector, output ready);
endinterface

/* src/dcps_front.sv */
// Front end: decodes an input word and precomputes the stateless arithmetic.
module dcps_front #(
  parameter int WORDS_PER_SECTOR   = dcps_pkg::WORDS_PER_SECTOR_DEF,
  parameter int SECTORS_PER_TRACK  = dcps_pkg::SECTORS_PER_TRACK_DEF,
  parameter int HEADS_PER_CYLINDER = dcps_pkg::HEADS_PER_CYLINDER_DEF,
  parameter int UNITS              = dcps_pkg::UNITS_DEF
) (
  input  logic [1:0]    cmd,
  input  logic          unit,
  input  logic [15:0]   e_code,
  input  logic [15:0]   a_value,
  input  logic [15:0]   cm_in,
  input  logic [15:0]   ads_in,
  input  logic [15:0]   adm_in,
  output dcps_pkg::job_t job
);

  localparam logic [15:0] WPS = 16'(WORDS_PER_SECTOR);

  // quotient (bits 10:5) and remainder (bits 4:0) of every 6-bit value by the track length
  function automatic logic [64*11-1:0] build_divtab();
    logic [64*11-1:0] t;
    t = '0;
    for (int i = 0; i < 64; i++) begin
      t[i*11 +: 11] = {6'(i / SECTORS_PER_TRACK), 5'(i % SECTORS_PER_TRACK)};
    end
    return t;
  endfunction

  localparam logic [64*11-1:0] DIV_TAB = build_divtab();

  logic [8:0]  cyl;
  logic        head;
  logic [4:0]  sec;
  logic [10:0] track;
  logic [5:0]  sec1;
  logic [10:0] tab_entry;
  logic [5:0]  tq;
  logic [4:0]  tr;
  logic [10:0] ntrack;
  logic [10:0] ncyl;
  logic        nhead;
  logic [7:0]  left;
  logic [7:0]  right;
  logic        sel_ok;

  assign cyl   = ads_in[15:7];
  assign head  = ads_in[6];
  assign sec   = ads_in[5:1];
  assign track = 11'(cyl * HEADS_PER_CYLINDER) + {10'd0, head};
  assign sec1  = {1'b0, sec} + 6'd1;
  // small quotient/remainder of a 6-bit value by the track length, from a constant table
  assign tab_entry = DIV_TAB[sec1 * 11 +: 11];
  assign tq    = tab_entry[10:5];
  assign tr    = tab_entry[4:0];
  assign ntrack = track + {5'd0, tq};
  assign ncyl   = 11'(ntrack / HEADS_PER_CYLINDER);
  assign nhead  = 1'(ntrack % HEADS_PER_CYLINDER);

  assign left   = a_value[15:8];
  assign right  = a_value[7:0];
  assign sel_ok = left[7] || (left[6] && (UNITS > 1));

  always_comb begin
    job           = '0;
    job.unit      = unit;
    job.a_value   = a_value;
    job.sel_unit  = ~left[7];
    job.ctl_hit   = (a_value == dcps_pkg::CTL_RESET);
    job.cm_zero   = (cm_in == 16'd0);
    job.q_value   = (cm_in < WPS) ? (16'd0 - cm_in) : (16'd0 - WPS);
    job.cm_value  = cm_in - WPS;
    job.next_ads  = {ncyl[8:0], nhead, tr, ads_in[0]};
    job.adm_value = adm_in + WPS;
    job.lsn       = 15'(track * SECTORS_PER_TRACK) + {10'd0, sec};
    if (right[7]) begin
      job.sel_op = dcps_pkg::OP_WRITE;
    end else if (right[6:4] != 3'd0) begin
      job.sel_op = dcps_pkg::OP_COMPARE;
    end else begin
      job.sel_op = dcps_pkg::OP_READ;
    end
    case (cmd)
      dcps_pkg::CMD_WRITE: begin
        case (e_code)
          dcps_pkg::FN_SELECT:  job.kind = sel_ok ? dcps_pkg::K_SELECT : dcps_pkg::K_CMD_BAD;
          dcps_pkg::FN_CONTROL: job.kind = dcps_pkg::K_CONTROL;
          dcps_pkg::FN_START:   job.kind = dcps_pkg::K_START;
          default:              job.kind = dcps_pkg::K_CMD_BAD;
        endcase
      end
      dcps_pkg::CMD_READ: begin
        job.kind = (e_code == dcps_pkg::FN_START) ? dcps_pkg::K_STATUS
                                                  : dcps_pkg::K_STAT_BAD;
      end
      dcps_pkg::CMD_TICK: begin
        job.kind = ({31'd0, unit} < UNITS) ? dcps_pkg::K_TICK : dcps_pkg::K_NOP;
      end
      default: job.kind = dcps_pkg::K_NOP;
    endcase
  end

endmodule

/* src/dcps_queue.sv */
// Two-entry queue between the front and back ends.
module dcps_queue (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           push,
  input  dcps_pkg::job_t push_data,
  output logic           full,
  input  logic           pop,
  output logic           not_empty,
  output dcps_pkg::job_t pop_data
);

  dcps_pkg::job_t mem_r [2];
  logic           wp_r, wp_nxt;
  logic           rp_r, rp_nxt;
  logic [1:0]     cnt_r, cnt_nxt;

  assign full      = (cnt_r == 2'd2);
  assign not_empty = (cnt_r != 2'd0);
  assign pop_data  = mem_r[rp_r];

  always_comb begin
    wp_nxt  = wp_r ^ push;
    rp_nxt  = rp_r ^ pop;
    cnt_nxt = cnt_r + {1'b0, push} - {1'b0, pop};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= 1'b0;
      rp_r  <= 1'b0;
      cnt_r <= 2'd0;
    end else begin
      wp_r  <= wp_nxt;
      rp_r  <= rp_nxt;
      cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wp_r] <= push_data;
    end
  end

endmodule

/* src/dcps_back.sv */
// Back end: per-unit state, phase sequencing and the result register.
module dcps_back (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              job_valid,
  input  dcps_pkg::job_t    job,
  output logic              job_take,
  output logic              res_valid,
  input  logic              res_ready,
  output dcps_pkg::result_t res
);

  logic [15:0]       status_r [2];
  logic [15:0]       status_nxt [2];
  logic [1:0]        op_r [2];
  logic [1:0]        op_nxt [2];
  logic [1:0]        active_r, active_nxt;
  logic              sel_r, sel_nxt;
  logic              valid_r, valid_nxt;
  dcps_pkg::result_t res_r, res_nxt;

  logic        s;
  logic        u;
  logic [2:0]  ph;
  logic        fail;

  assign job_take  = job_valid && (!valid_r || res_ready);
  assign res_valid = valid_r;
  assign res       = res_r;
  assign s         = sel_r;
  assign u         = job.unit;
  assign ph        = status_r[u][2:0];

  always_comb begin
    status_nxt = status_r;
    op_nxt     = op_r;
    active_nxt = active_r;
    sel_nxt    = sel_r;
    res_nxt    = '0;
    fail       = 1'b0;
    case (job.kind)
      dcps_pkg::K_SELECT: begin
        sel_nxt              = job.sel_unit;
        op_nxt[job.sel_unit] = job.sel_op;
      end
      dcps_pkg::K_CONTROL: begin
        if (job.ctl_hit) begin
          status_nxt[s] = '0;
          active_nxt[s] = 1'b0;
        end
      end
      dcps_pkg::K_START: begin
        if (!active_r[s]) begin
          res_nxt.reg_write_mask  = dcps_pkg::WM_ADS;
          res_nxt.ads_value       = job.a_value;
          res_nxt.suspend_request = 1'b1;
          active_nxt[s]           = 1'b1;
          status_nxt[s]           = '0;
        end
      end
      dcps_pkg::K_CMD_BAD:  res_nxt.cmd_error  = 1'b1;
      dcps_pkg::K_STATUS:   res_nxt.status_out = status_r[s];
      dcps_pkg::K_STAT_BAD: res_nxt.cmd_error  = 1'b1;
      dcps_pkg::K_TICK: begin
        if (active_r[u]) begin
          res_nxt.suspend_request = 1'b1;
          case (ph)
            3'd0: begin
              if (job.cm_zero) begin
                fail = 1'b1;
              end else begin
                status_nxt[u][2:0] = 3'd1;
              end
            end
            3'd1: status_nxt[u][2:0] = 3'd2;
            3'd2: begin
              res_nxt.reg_write_mask = dcps_pkg::WM_QCM;
              res_nxt.q_value        = job.q_value;
              res_nxt.cm_value       = job.cm_value;
              status_nxt[u][2:0]     = 3'd3;
            end
            3'd3: status_nxt[u][2:0] = 3'd4;
            3'd4: begin
              res_nxt.xfer_op = (op_r[u] == dcps_pkg::OP_WRITE) ? dcps_pkg::XF_TO_DSK
                                                                : dcps_pkg::XF_TO_MEM;
              res_nxt.xfer_sector    = job.lsn;
              res_nxt.reg_write_mask = dcps_pkg::WM_ADM;
              res_nxt.adm_value      = job.adm_value;
              status_nxt[u][2:0]     = 3'd6;  // phase 5 is skipped
            end
            3'd5: status_nxt[u][2:0] = 3'd6;
            3'd6: begin
              if (job.cm_zero) begin
                res_nxt.suspend_request = 1'b0;
                active_nxt[u]           = 1'b0;
                status_nxt[u]           = '0;
                res_nxt.interrupt_level = dcps_pkg::IRQ_BASE + {3'd0, u};
              end else begin
                res_nxt.reg_write_mask = dcps_pkg::WM_ADS;
                res_nxt.ads_value      = job.next_ads;
                status_nxt[u][2:0]     = 3'd0;
              end
            end
            default: fail = 1'b1;
          endcase
          if (fail) begin
            res_nxt.suspend_request = 1'b0;
            status_nxt[u]           = status_r[u] | dcps_pkg::ST_ERR_BITS;
            active_nxt[u]           = 1'b0;
            res_nxt.interrupt_level = dcps_pkg::IRQ_BASE + {3'd0, u};
          end
        end
      end
      default: ;
    endcase
  end

  always_comb begin
    valid_nxt = valid_r;
    if (job_take) begin
      valid_nxt = 1'b1;
    end else if (res_ready) begin
      valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      status_r[0] <= '0;
      status_r[1] <= '0;
      op_r[0]     <= dcps_pkg::OP_READ;
      op_r[1]     <= dcps_pkg::OP_READ;
      active_r    <= '0;
      sel_r       <= 1'b0;
      valid_r     <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
      if (job_take) begin
        status_r <= status_nxt;
        op_r     <= op_nxt;
        active_r <= active_nxt;
        sel_r    <= sel_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (job_take) begin
      res_r <= res_nxt;
    end
  end

endmodule

/* src/disk_controller_phase_sequencer_top.sv */
// Two-unit disk controller phase sequencer, top level.
// Channels: in_ch takes command writes, status reads and per-unit phase
// ticks; out_ch returns exactly one result word per input word, in order.
// Both use valid/ready; a word moves on a clock edge with both high.
// The front decodes each word and precomputes word-count and disk-address
// arithmetic; a two-entry queue feeds the back end, which owns the unit
// status, operation and active flags and writes the result register.
// An accepted input word is written into the queue; the back end takes it from there and registers its result.
// Throughput: one word per cycle while out_ch.ready is high, set by the single back-end state update.
// Reset (rst_n low, synchronous): queue and result register empty, all unit
// state zero, unit 0 selected, operations set to read.
// When out_ch stalls the result holds; the queue keeps taking words until
// it holds two, then in_ch.ready drops.
module disk_controller_phase_sequencer_top #(
  parameter int WORDS_PER_SECTOR   = dcps_pkg::WORDS_PER_SECTOR_DEF,
  parameter int SECTORS_PER_TRACK  = dcps_pkg::SECTORS_PER_TRACK_DEF,
  parameter int HEADS_PER_CYLINDER = dcps_pkg::HEADS_PER_CYLINDER_DEF,
  parameter int UNITS              = dcps_pkg::UNITS_DEF
) (
  input logic        clk,
  input logic        rst_n,
  dcps_in_if.sink    in_ch,
  dcps_out_if.source out_ch
);

  dcps_pkg::job_t    front_job;
  dcps_pkg::job_t    q_job;
  dcps_pkg::result_t res;
  logic              q_full;
  logic              q_not_empty;
  logic              q_pop;
  logic              push;

  assign in_ch.ready = ~q_full;
  assign push        = in_ch.valid && ~q_full;

  dcps_front #(
    .WORDS_PER_SECTOR  (WORDS_PER_SECTOR),
    .SECTORS_PER_TRACK (SECTORS_PER_TRACK),
    .HEADS_PER_CYLINDER(HEADS_PER_CYLINDER),
    .UNITS             (UNITS)
  ) u_front (
    .cmd    (in_ch.cmd),
    .unit   (in_ch.unit),
    .e_code (in_ch.e_code),
    .a_value(in_ch.a_value),
    .cm_in  (in_ch.cm_in),
    .ads_in (in_ch.ads_in),
    .adm_in (in_ch.adm_in),
    .job    (front_job)
  );

  dcps_queue u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (push),
    .push_data(front_job),
    .full     (q_full),
    .pop      (q_pop),
    .not_empty(q_not_empty),
    .pop_data (q_job)
  );

  dcps_back u_back (
    .clk      (clk),
    .rst_n    (rst_n),
    .job_valid(q_not_empty),
    .job      (q_job),
    .job_take (q_pop),
    .res_valid(out_ch.valid),
    .res_ready(out_ch.ready),
    .res      (res)
  );

  assign out_ch.reg_write_mask  = res.reg_write_mask;
  assign out_ch.q_value         = res.q_value;
  assign out_ch.cm_value        = res.cm_value;
  assign out_ch.ads_value       = res.ads_value;
  assign out_ch.adm_value       = res.adm_value;
  assign out_ch.status_out      = res.status_out;
  assign out_ch.interrupt_level = res.interrupt_level;
  assign out_ch.suspend_request = res.suspend_request;
  assign out_ch.cmd_error       = res.cmd_error;
  assign out_ch.xfer_op         = res.xfer_op;
  assign out_ch.xfer_sector     = res.xfer_sector;

endmodule
